FILE: src/tap_pkg.sv
package tap_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_ACCUM,
        ST_FLUSH,
        ST_READ,
        ST_LOAD,
        ST_SHOW
    } tap_state_t;

    // Configuration register indexes
    localparam logic REG_SPATIAL  = 1'b0;
    localparam logic REG_SPECTRAL = 1'b1;

    // Size both registers take out of reset, before saturation to the maximum
    localparam int SIZE_RESET = 32;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic rd_issue;
        logic load_out;
        logic out_done;
    } tap_cmd_t;

    typedef struct packed {
        logic cube_done;
        logic clr_end;
        logic rd_last;
    } tap_stat_t;

endpackage

FILE: src/tap_ctrl.sv
module tap_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wen,
    input  logic               in_valid,
    input  logic               out_stall,
    input  tap_pkg::tap_stat_t stat,
    output tap_pkg::tap_cmd_t  cmd,
    output logic               in_stall,
    output logic               out_valid
);
    import tap_pkg::*;

    tap_state_t state_reg;
    tap_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clr_end)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                if (in_valid && stat.cube_done)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: state_next = ST_READ;
            ST_READ:  state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_SHOW;
            ST_SHOW:
            begin
                if (!out_stall)
                begin
                    state_next = stat.rd_last ? ST_ACCUM : ST_READ;
                end
            end
            default:  state_next = ST_CLEAR;
        endcase
        // a configuration write abandons the cube and restarts the clearing pass
        if (cfg_wen)
        begin
            state_next = ST_CLEAR;
        end
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.clr_step = 1'b1;
            ST_ACCUM:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_FLUSH: cmd = '0;
            ST_READ:  cmd.rd_issue = 1'b1;
            ST_LOAD:  cmd.load_out = 1'b1;
            ST_SHOW:
            begin
                out_valid    = 1'b1;
                cmd.out_done = !out_stall;
            end
            default:  cmd = '0;
        endcase
    end

endmodule

FILE: src/tap_dp.sv
module tap_dp #(
    parameter int MAX_SPATIAL  = 32,
    parameter int MAX_SPECTRAL = 32,
    parameter int SAMPLE_BITS  = 16,
    localparam int NUM_POS  = MAX_SPATIAL + MAX_SPECTRAL - 1,
    localparam int PW       = (NUM_POS > 1) ? $clog2(NUM_POS) : 1,
    localparam int MAX_DIM  = (MAX_SPATIAL > MAX_SPECTRAL) ? MAX_SPATIAL : MAX_SPECTRAL,
    localparam int SB       = $clog2(MAX_DIM + 1),
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_DIM)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic                   cfg_index,
    input  logic [SB-1:0]          cfg_wdata,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  tap_pkg::tap_cmd_t      cmd,
    output tap_pkg::tap_stat_t     stat,
    output logic [PW-1:0]          position,
    output logic [SUM_BITS-1:0]    zero_sum,
    output logic                   zero_valid,
    output logic [SUM_BITS-1:0]    plus_sum,
    output logic [SUM_BITS-1:0]    minus_sum,
    output logic                   last
);
    import tap_pkg::*;

    localparam int RIW = (MAX_SPATIAL > 1) ? $clog2(MAX_SPATIAL) : 1;
    localparam int CIW = (MAX_SPECTRAL > 1) ? $clog2(MAX_SPECTRAL) : 1;
    localparam int XW  = (PW > SB) ? PW : SB;
    localparam int SPAT_RST = (SIZE_RESET > MAX_SPATIAL) ? MAX_SPATIAL : SIZE_RESET;
    localparam int SPEC_RST = (SIZE_RESET > MAX_SPECTRAL) ? MAX_SPECTRAL : SIZE_RESET;

    // accumulator memories
    logic [SUM_BITS-1:0] row_mem [MAX_SPATIAL];
    logic [SUM_BITS-1:0] dia_mem [NUM_POS];
    logic [SUM_BITS-1:0] ant_mem [NUM_POS];

    // control state
    logic [SB-1:0]  spat_reg;
    logic [SB-1:0]  spec_reg;
    logic [RIW-1:0] row_reg;
    logic [CIW-1:0] col_reg;
    logic [PW-1:0]  pos_reg;
    logic           a_valid_reg;
    logic           prev_valid_reg;

    // payload
    logic [SAMPLE_BITS-1:0] a_sample_reg;
    logic [RIW-1:0]         a_row_addr_reg;
    logic [PW-1:0]          a_dia_addr_reg;
    logic [PW-1:0]          a_ant_addr_reg;
    logic [RIW-1:0]         prev_row_addr_reg;
    logic [PW-1:0]          prev_dia_addr_reg;
    logic [PW-1:0]          prev_ant_addr_reg;
    logic [SUM_BITS-1:0]    prev_row_data_reg;
    logic [SUM_BITS-1:0]    prev_dia_data_reg;
    logic [SUM_BITS-1:0]    prev_ant_data_reg;
    logic [SUM_BITS-1:0]    rd_row_reg;
    logic [SUM_BITS-1:0]    rd_dia_reg;
    logic [SUM_BITS-1:0]    rd_ant_reg;
    logic [PW-1:0]          out_pos_reg;
    logic [SUM_BITS-1:0]    out_zero_reg;
    logic                   out_zv_reg;
    logic [SUM_BITS-1:0]    out_plus_reg;
    logic [SUM_BITS-1:0]    out_minus_reg;
    logic                   out_last_reg;

    logic [SB-1:0]       size_nz;
    logic [SB-1:0]       spat_wr;
    logic [SB-1:0]       spec_wr;
    logic [PW-1:0]       dia_addr;
    logic [PW-1:0]       ant_addr;
    logic                col_end;
    logic                row_end;
    logic [PW-1:0]       npos_m1;
    logic                pos_zv;
    logic                pos_in_row;
    logic [SUM_BITS-1:0] sum_row;
    logic [SUM_BITS-1:0] sum_dia;
    logic [SUM_BITS-1:0] sum_ant;
    logic                row_we;
    logic [RIW-1:0]      row_wa;
    logic [SUM_BITS-1:0] row_wd;
    logic [RIW-1:0]      row_ra;
    logic                da_we;
    logic [PW-1:0]       dia_wa;
    logic [PW-1:0]       ant_wa;
    logic [SUM_BITS-1:0] dia_wd;
    logic [SUM_BITS-1:0] ant_wd;
    logic [PW-1:0]       dia_ra;
    logic [PW-1:0]       ant_ra;

    // treat zero as one, saturate at the maximum
    always_comb
    begin
        size_nz = (cfg_wdata == '0) ? SB'(1) : cfg_wdata;
        spat_wr = (cfg_wdata > SB'(MAX_SPATIAL)) ? SB'(MAX_SPATIAL) : size_nz;
        spec_wr = (cfg_wdata > SB'(MAX_SPECTRAL)) ? SB'(MAX_SPECTRAL) : size_nz;
    end

    always_comb
    begin
        dia_addr   = PW'(row_reg) + PW'(spec_reg) - PW'(1) - PW'(col_reg);
        ant_addr   = PW'(row_reg) + PW'(col_reg);
        col_end    = (SB'(col_reg) == spec_reg - SB'(1));
        row_end    = (SB'(row_reg) == spat_reg - SB'(1));
        npos_m1    = PW'(spat_reg) + PW'(spec_reg) - PW'(2);
        pos_zv     = (XW'(pos_reg) < XW'(spat_reg));
        pos_in_row = (XW'(pos_reg) < XW'(MAX_SPATIAL));

        stat.cube_done = col_end && row_end;
        stat.clr_end   = (pos_reg == PW'(NUM_POS - 1));
        stat.rd_last   = (pos_reg == npos_m1);
    end

    // forward the previous write where the registered read raced it
    always_comb
    begin
        sum_row = ((prev_valid_reg && prev_row_addr_reg == a_row_addr_reg) ?
                   prev_row_data_reg : rd_row_reg) + SUM_BITS'(a_sample_reg);
        sum_dia = ((prev_valid_reg && prev_dia_addr_reg == a_dia_addr_reg) ?
                   prev_dia_data_reg : rd_dia_reg) + SUM_BITS'(a_sample_reg);
        sum_ant = ((prev_valid_reg && prev_ant_addr_reg == a_ant_addr_reg) ?
                   prev_ant_data_reg : rd_ant_reg) + SUM_BITS'(a_sample_reg);
    end

    always_comb
    begin
        row_we = 1'b0;
        row_wa = a_row_addr_reg;
        row_wd = sum_row;
        da_we  = 1'b0;
        dia_wa = a_dia_addr_reg;
        ant_wa = a_ant_addr_reg;
        dia_wd = sum_dia;
        ant_wd = sum_ant;
        if (a_valid_reg)
        begin
            row_we = 1'b1;
            da_we  = 1'b1;
        end
        else if (cmd.clr_step || cmd.rd_issue)
        begin
            // zero the entry: whole sweep when clearing, the one just read otherwise
            row_we = cmd.clr_step ? pos_in_row : pos_zv;
            row_wa = RIW'(pos_reg);
            row_wd = '0;
            da_we  = 1'b1;
            dia_wa = pos_reg;
            ant_wa = pos_reg;
            dia_wd = '0;
            ant_wd = '0;
        end
        row_ra = cmd.rd_issue ? RIW'(pos_reg) : row_reg;
        dia_ra = cmd.rd_issue ? pos_reg : dia_addr;
        ant_ra = cmd.rd_issue ? pos_reg : ant_addr;
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_wa] <= row_wd;
        end
        rd_row_reg <= row_mem[row_ra];
    end

    always_ff @(posedge clk)
    begin
        if (da_we)
        begin
            dia_mem[dia_wa] <= dia_wd;
        end
        rd_dia_reg <= dia_mem[dia_ra];
    end

    always_ff @(posedge clk)
    begin
        if (da_we)
        begin
            ant_mem[ant_wa] <= ant_wd;
        end
        rd_ant_reg <= ant_mem[ant_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spat_reg       <= SB'(SPAT_RST);
            spec_reg       <= SB'(SPEC_RST);
            row_reg        <= '0;
            col_reg        <= '0;
            pos_reg        <= '0;
            a_valid_reg    <= 1'b0;
            prev_valid_reg <= 1'b0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_SPATIAL:  spat_reg <= spat_wr;
                REG_SPECTRAL: spec_reg <= spec_wr;
                default:      spat_reg <= spat_reg;
            endcase
            row_reg        <= '0;
            col_reg        <= '0;
            pos_reg        <= '0;
            a_valid_reg    <= 1'b0;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg    <= cmd.accept;
            prev_valid_reg <= a_valid_reg;
            if (cmd.accept)
            begin
                if (col_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_end ? '0 : row_reg + RIW'(1);
                end
                else
                begin
                    col_reg <= col_reg + CIW'(1);
                end
            end
            if (cmd.clr_step)
            begin
                pos_reg <= stat.clr_end ? '0 : pos_reg + PW'(1);
            end
            else if (cmd.out_done)
            begin
                pos_reg <= stat.rd_last ? '0 : pos_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            a_sample_reg   <= sample;
            a_row_addr_reg <= row_reg;
            a_dia_addr_reg <= dia_addr;
            a_ant_addr_reg <= ant_addr;
        end
        if (a_valid_reg)
        begin
            prev_row_addr_reg <= a_row_addr_reg;
            prev_dia_addr_reg <= a_dia_addr_reg;
            prev_ant_addr_reg <= a_ant_addr_reg;
            prev_row_data_reg <= sum_row;
            prev_dia_data_reg <= sum_dia;
            prev_ant_data_reg <= sum_ant;
        end
        if (cmd.load_out)
        begin
            out_pos_reg   <= pos_reg;
            out_zero_reg  <= pos_zv ? rd_row_reg : '0;
            out_zv_reg    <= pos_zv;
            out_plus_reg  <= rd_dia_reg;
            out_minus_reg <= rd_ant_reg;
            out_last_reg  <= stat.rd_last;
        end
    end

    assign position   = out_pos_reg;
    assign zero_sum   = out_zero_reg;
    assign zero_valid = out_zv_reg;
    assign plus_sum   = out_plus_reg;
    assign minus_sum  = out_minus_reg;
    assign last       = out_last_reg;

endmodule

FILE: src/three_angle_projection_summer.sv
// Three-angle projection summer. Samples of a cube arrive in row-major order
// (spatial row, then spectral column) and each is added to its row sum, its
// diagonal sum and its anti-diagonal sum, held in three memories. During a
// cube the block takes one sample per cycle: each memory runs a read, add and
// write pipeline with the previous write forwarded. After the final sample of
// a cube a flush state drains that pipeline; then the block stalls its input
// and reads out spatial_size + spectral_size - 1 results, each through a
// memory read, an output load and an output beat that holds while the output
// is stalled, zeroing each entry as it is read.
// After reset and after every configuration write the input is stalled for a
// clearing pass over all MAX_SPATIAL + MAX_SPECTRAL - 1 positions (63 by
// default); any write abandons a partly received cube.
module three_angle_projection_summer #(
    parameter int MAX_SPATIAL  = 32,
    parameter int MAX_SPECTRAL = 32,
    parameter int SAMPLE_BITS  = 16,
    localparam int NUM_POS  = MAX_SPATIAL + MAX_SPECTRAL - 1,
    localparam int PW       = (NUM_POS > 1) ? $clog2(NUM_POS) : 1,
    localparam int MAX_DIM  = (MAX_SPATIAL > MAX_SPECTRAL) ? MAX_SPATIAL : MAX_SPECTRAL,
    localparam int SB       = $clog2(MAX_DIM + 1),
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_DIM)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic                   cfg_index,
    input  logic [SB-1:0]          cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [PW-1:0]          position,
    output logic [SUM_BITS-1:0]    zero_sum,
    output logic                   zero_valid,
    output logic [SUM_BITS-1:0]    plus_sum,
    output logic [SUM_BITS-1:0]    minus_sum,
    output logic                   last
);
    import tap_pkg::*;

    tap_cmd_t  cmd;
    tap_stat_t stat;

    tap_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    tap_dp #(
        .MAX_SPATIAL  (MAX_SPATIAL),
        .MAX_SPECTRAL (MAX_SPECTRAL),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .sample     (sample),
        .cmd        (cmd),
        .stat       (stat),
        .position   (position),
        .zero_sum   (zero_sum),
        .zero_valid (zero_valid),
        .plus_sum   (plus_sum),
        .minus_sum  (minus_sum),
        .last       (last)
    );

endmodule

FILE: src/tap_checker.sv
module tap_checker #(
    parameter int MAX_SPATIAL  = 32,
    parameter int MAX_SPECTRAL = 32,
    parameter int SAMPLE_BITS  = 16,
    localparam int NUM_POS  = MAX_SPATIAL + MAX_SPECTRAL - 1,
    localparam int PW       = (NUM_POS > 1) ? $clog2(NUM_POS) : 1,
    localparam int MAX_DIM  = (MAX_SPATIAL > MAX_SPECTRAL) ? MAX_SPATIAL : MAX_SPECTRAL,
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_DIM)
) (
    input logic                clk,
    input logic                rst_n,
    input logic                cfg_wen,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [PW-1:0]       position,
    input logic [SUM_BITS-1:0] zero_sum,
    input logic                zero_valid,
    input logic [SUM_BITS-1:0] plus_sum,
    input logic [SUM_BITS-1:0] minus_sum,
    input logic                last
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall && !cfg_wen |=> out_valid && $stable(position) &&
        $stable(zero_sum) && $stable(zero_valid) && $stable(plus_sum) &&
        $stable(minus_sum) && $stable(last))
        else $error("stalled result changed");

    a_no_input_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open during readout");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last |=> !out_valid)
        else $error("result after last of run");

    a_zero_masked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero_valid |-> zero_sum == '0)
        else $error("row sum shown outside spatial range");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wen |=> in_stall && !out_valid)
        else $error("block not clearing after configuration write");

endmodule

bind three_angle_projection_summer tap_checker #(
    .MAX_SPATIAL  (MAX_SPATIAL),
    .MAX_SPECTRAL (MAX_SPECTRAL),
    .SAMPLE_BITS  (SAMPLE_BITS)
) u_tap_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .position   (position),
    .zero_sum   (zero_sum),
    .zero_valid (zero_valid),
    .plus_sum   (plus_sum),
    .minus_sum  (minus_sum),
    .last       (last)
);

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
    import tap_pkg::*;

    localparam int ROWS_MAX      = 32;
    localparam int COLS_MAX      = 32;
    localparam int POS_COUNT     = ROWS_MAX + COLS_MAX - 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_ITEMS  = 320;

    typedef struct packed {
        logic [5:0]  position;
        logic [20:0] zero_sum;
        logic        zero_valid;
        logic [20:0] plus_sum;
        logic [20:0] minus_sum;
        logic        last;
    } projection_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wen = 1'b0;
    logic        cfg_index = REG_SPATIAL;
    logic [5:0]  cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] sample = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [5:0]  position;
    logic [20:0] zero_sum;
    logic        zero_valid;
    logic [20:0] plus_sum;
    logic [20:0] minus_sum;
    logic        last;

    // projections predicted for the cube in flight, and the ones awaiting readout
    logic [21:0] row_acc [ROWS_MAX];
    logic [21:0] diag_acc [POS_COUNT];
    logic [21:0] anti_acc [POS_COUNT];
    int          row_ptr;
    int          col_ptr;
    int          rows_cfg = ROWS_MAX;
    int          cols_cfg = COLS_MAX;
    projection_t projections_due [$];

    int  errors;
    int  samples_sent;
    int  cubes_done;
    int  results_seen;
    int  size_writes;
    int  idle_cycles;
    int  stall_left;
    bit  offering;
    bit  sender_gaps = 1'b1;
    bit  receiver_gaps = 1'b1;

    three_angle_projection_summer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .position   (position),
        .zero_sum   (zero_sum),
        .zero_valid (zero_valid),
        .plus_sum   (plus_sum),
        .minus_sum  (minus_sum),
        .last       (last)
    );

    always #1 clk = ~clk;

    function automatic void clear_sums();
        for (int k = 0; k < ROWS_MAX; k++)
            row_acc[k] = '0;
        for (int k = 0; k < POS_COUNT; k++)
        begin
            diag_acc[k] = '0;
            anti_acc[k] = '0;
        end
        row_ptr = 0;
        col_ptr = 0;
    endfunction

    function automatic int clamp_size(input logic [5:0] raw, input int limit);
        if (raw == 0)
            return 1;
        if (raw > limit)
            return limit;
        return int'(raw);
    endfunction

    // Add one sample to its three projections; queue the readout once the cube is full
    function automatic void fold_sample(input logic [15:0] s);
        int          diag;
        int          anti;
        int          npos;
        projection_t p;
        diag = row_ptr + cols_cfg - 1 - col_ptr;
        anti = row_ptr + col_ptr;
        row_acc[row_ptr] += s;
        diag_acc[diag]   += s;
        anti_acc[anti]   += s;
        col_ptr++;
        if (col_ptr >= cols_cfg)
        begin
            col_ptr = 0;
            row_ptr++;
        end
        if (row_ptr < rows_cfg)
            return;
        npos = rows_cfg + cols_cfg - 1;
        for (int k = 0; k < npos; k++)
        begin
            p.position   = k[5:0];
            p.zero_valid = (k < rows_cfg);
            p.zero_sum   = p.zero_valid ? row_acc[k][20:0] : '0;
            p.plus_sum   = diag_acc[k][20:0];
            p.minus_sum  = anti_acc[k][20:0];
            p.last       = (k + 1 == npos);
            projections_due.push_back(p);
        end
        cubes_done++;
        clear_sums();
    endfunction

    function automatic int pick_gap();
        int r;
        if (!sender_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'h0000;
        if (r < 20)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // Mostly small sizes; now and then zero or a value at or past the maximum
    function automatic logic [5:0] pick_size_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return 6'd0;
        if (r < 12)
            return 6'($urandom_range(32, 63));
        return 6'($urandom_range(1, 6));
    endfunction

    task automatic sample_idle();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge clk);
    endtask

    task automatic wait_drain();
        while (projections_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_sample(input logic [15:0] s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            if (offering)
            begin
                in_valid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        offering = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        fold_sample(s);
        samples_sent++;
    endtask

    // Write one size register once the block has nothing left to deliver
    task automatic set_size(input logic idx, input logic [5:0] value);
        sample_idle();
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        if (idx == REG_SPATIAL)
            rows_cfg = clamp_size(value, ROWS_MAX);
        else
            cols_cfg = clamp_size(value, COLS_MAX);
        clear_sums();
        size_writes++;
    endtask

    task automatic send_cube();
        repeat (rows_cfg * cols_cfg) send_sample(pick_sample());
    endtask

    // Spatial size out of reset: one spectral column of full height, every sample at full scale
    task automatic test_reset_column();
        set_size(REG_SPECTRAL, 6'd1);
        repeat (ROWS_MAX) send_sample(16'hFFFF);
    endtask

    task automatic test_size_limits();
        set_size(REG_SPATIAL, 6'd0);
        set_size(REG_SPECTRAL, 6'd0);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        // one row saturated to full width: row sum at its top value
        set_size(REG_SPECTRAL, 6'd33);
        repeat (COLS_MAX) send_sample(16'hFFFF);
    endtask

    task automatic test_abandon();
        set_size(REG_SPATIAL, 6'd3);
        set_size(REG_SPECTRAL, 6'd2);
        repeat (4) send_sample(16'h1234);
        set_size(REG_SPECTRAL, 6'd2);
        repeat (3) send_sample(16'hABCD);
        set_size(REG_SPATIAL, 6'd3);
        send_cube();
    endtask

    task automatic test_random_cubes();
        int          taken;
        int          round;
        int          part;
        logic [5:0]  first_code;
        logic [5:0]  second_code;
        logic        first_reg;
        taken = 0;
        round = 0;
        while (taken < RANDOM_ITEMS)
        begin
            sender_gaps   = ($urandom_range(0, 3) != 0);
            receiver_gaps = ($urandom_range(0, 3) != 0);
            if (round == 0 || $urandom_range(0, 2) == 0)
            begin
                first_reg   = $urandom_range(0, 1) ? REG_SPECTRAL : REG_SPATIAL;
                first_code  = pick_size_code();
                second_code = (clamp_size(first_code, ROWS_MAX) > 8)
                              ? 6'($urandom_range(1, 3)) : pick_size_code();
                if (clamp_size(second_code, ROWS_MAX) > 8 && clamp_size(first_code, ROWS_MAX) > 3)
                    second_code = 6'($urandom_range(1, 3));
                set_size(first_reg, first_code);
                set_size(~first_reg, second_code);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                // broken cube: part of it, then a size write throws it away
                part = $urandom_range(0, rows_cfg * cols_cfg - 1);
                repeat (part) send_sample(pick_sample());
                taken += part;
                set_size(REG_SPATIAL, 6'(rows_cfg));
            end
            send_cube();
            taken += rows_cfg * cols_cfg;
            if (round % 10 == 0)
            begin
                // hold the sender until the whole readout is through
                sample_idle();
                wait_drain();
                @(posedge clk);
            end
            round++;
        end
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [20:0] want,
                               input logic [20:0] got, input logic [5:0] pos);
        if (want !== got)
        begin
            if (errors < 10)
                $display("Mismatch at position %0d, %s: expected %0d, got %0d",
                         pos, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : watch_results
        projection_t want;
        if (out_valid && !out_stall)
        begin
            results_seen++;
            if (projections_due.size() == 0)
            begin
                if (errors < 10)
                    $display("Unexpected result at position %0d", position);
                errors++;
            end
            else
            begin
                want = projections_due.pop_front();
                check_field("position", 21'(want.position), 21'(position), want.position);
                check_field("zero_sum", want.zero_sum, zero_sum, want.position);
                check_field("zero_valid", 21'(want.zero_valid), 21'(zero_valid), want.position);
                check_field("plus_sum", want.plus_sum, plus_sum, want.position);
                check_field("minus_sum", want.minus_sum, minus_sum, want.position);
                check_field("last", 21'(want.last), 21'(last), want.position);
            end
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (receiver_gaps && $urandom_range(0, 99) < 25)
        begin
            out_stall <= 1'b1;
            stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                      : $urandom_range(8, 40);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no beat for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, projections_due.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        clear_sums();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_column();
        test_size_limits();
        test_abandon();
        test_random_cubes();
        sample_idle();
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d samples over %0d complete cubes with %0d size writes;",
                 samples_sent, cubes_done, size_writes);
        $display("checked %0d projection results, %0d mismatches", results_seen, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
